// File: hw/rtl/smf_pkg.sv
`default_nettype none

package smf_pkg;

    // Default sizing of the table and of the occurrence counters.
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field widths of the sample and result ports.
    localparam int VALUE_W      = 32;
    localparam int MODE_COUNT_W = 16;

    // Control bits of a token as it travels down the chain of cells.
    typedef struct packed {
        logic valid;    // A sample occupies this slot of the chain.
        logic last;     // The sample closes its set.
        logic hit;      // The sample was counted or entered by an earlier cell.
        logic have;     // The running best below holds a real entry.
    } token_t;

endpackage

`default_nettype wire

// File: hw/rtl/smf_cell.sv
`default_nettype none

module smf_cell #(
    parameter int COUNT_WIDTH = smf_pkg::COUNT_WIDTH_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire smf_pkg::token_t                tok_in,
    input  wire logic signed [smf_pkg::VALUE_W-1:0] value_in,
    input  wire logic signed [smf_pkg::VALUE_W-1:0] best_val_in,
    input  wire logic [COUNT_WIDTH-1:0]         best_cnt_in,
    output smf_pkg::token_t                     tok_out,
    output logic signed [smf_pkg::VALUE_W-1:0]  value_out,
    output logic signed [smf_pkg::VALUE_W-1:0]  best_val_out,
    output logic [COUNT_WIDTH-1:0]              best_cnt_out
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    // Entry held by this cell.
    logic                               used_reg, used_next;
    logic signed [smf_pkg::VALUE_W-1:0] entry_val_reg, entry_val_next;
    logic [COUNT_WIDTH-1:0]             entry_cnt_reg, entry_cnt_next;

    // Token handed on to the next cell.
    smf_pkg::token_t                    tok_reg, tok_next;
    logic signed [smf_pkg::VALUE_W-1:0] value_reg, value_next;
    logic signed [smf_pkg::VALUE_W-1:0] best_val_reg, best_val_next;
    logic [COUNT_WIDTH-1:0]             best_cnt_reg, best_cnt_next;

    logic                               match;
    logic                               claim;
    logic                               used_upd;
    logic signed [smf_pkg::VALUE_W-1:0] val_upd;
    logic [COUNT_WIDTH-1:0]             cnt_upd;
    logic                               take;

    // Count the sample here on a match, or enter it into an empty cell.
    always_comb
    begin
        match    = tok_in.valid && !tok_in.hit && used_reg && (value_in == entry_val_reg);
        claim    = tok_in.valid && !tok_in.hit && !used_reg;
        used_upd = used_reg || claim;
        val_upd  = claim ? value_in : entry_val_reg;
        if (claim)
        begin
            cnt_upd = CNT_ONE;
        end
        else if (match && (entry_cnt_reg != CNT_MAX))
        begin
            cnt_upd = entry_cnt_reg + CNT_ONE;
        end
        else
        begin
            cnt_upd = entry_cnt_reg;
        end
    end

    // Each sample folds this entry into its running best; ties go to the smaller value.
    always_comb
    begin
        take = used_upd && (!tok_in.have || (cnt_upd > best_cnt_in) ||
               ((cnt_upd == best_cnt_in) && (val_upd < best_val_in)));

        tok_next.valid = tok_in.valid;
        tok_next.last  = tok_in.last;
        tok_next.hit   = tok_in.hit || match || claim;
        tok_next.have  = tok_in.have || take;
        value_next     = value_in;
        best_val_next  = take ? val_upd : best_val_in;
        best_cnt_next  = take ? cnt_upd : best_cnt_in;

        entry_val_next = val_upd;
        entry_cnt_next = cnt_upd;
        if (tok_in.valid && tok_in.last)
        begin
            // The set is closed: free the cell for the next set.
            used_next = 1'b0;
        end
        else
        begin
            used_next = used_upd;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        entry_val_reg <= entry_val_next;
        entry_cnt_reg <= entry_cnt_next;
        value_reg     <= value_next;
        best_val_reg  <= best_val_next;
        best_cnt_reg  <= best_cnt_next;
    end

    assign tok_out      = tok_reg;
    assign value_out    = value_reg;
    assign best_val_out = best_val_reg;
    assign best_cnt_out = best_cnt_reg;

endmodule

`default_nettype wire

// File: hw/rtl/statistical_mode_finder.sv
`default_nettype none

// Statistical mode finder. Samples of a set enter one per clock cycle (busy stays low) and
// travel down a chain of TABLE_DEPTH cells, one cell per cycle; each cell holds one distinct
// value with its saturating count, so a set may hold up to TABLE_DEPTH distinct values and
// further new values are dropped and flagged in table_overflow. The sample marked last_item
// collects the most frequent value (smallest value on ties) as it passes the cells and frees
// them behind it, so the next set may follow in the very next cycle. Its result is on the
// mode ports, with mode_valid high, for one cycle once the sample has passed the register of
// every cell and the result register at the tail. The receiver cannot stall and must take the
// result in that cycle. Counts wider than 16 bits are reported clamped to 65535.
module statistical_mode_finder #(
    parameter int TABLE_DEPTH = smf_pkg::TABLE_DEPTH_DEF,
    parameter int COUNT_WIDTH = smf_pkg::COUNT_WIDTH_DEF
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  wire                                      start,
    output logic                                     busy,
    input  wire logic signed [smf_pkg::VALUE_W-1:0]  sample_value,
    input  wire                                      last_item,
    output logic                                     mode_valid,
    output logic signed [smf_pkg::VALUE_W-1:0]       mode_value,
    output logic [smf_pkg::MODE_COUNT_W-1:0]         mode_count,
    output logic                                     table_overflow
);

    localparam int WIDE_W = (COUNT_WIDTH > smf_pkg::MODE_COUNT_W) ?
                            COUNT_WIDTH : smf_pkg::MODE_COUNT_W;
    localparam logic [WIDE_W-1:0] OUT_MAX = WIDE_W'({smf_pkg::MODE_COUNT_W{1'b1}});

    smf_pkg::token_t                    tok      [0:TABLE_DEPTH];
    logic signed [smf_pkg::VALUE_W-1:0] value    [0:TABLE_DEPTH];
    logic signed [smf_pkg::VALUE_W-1:0] best_val [0:TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0]             best_cnt [0:TABLE_DEPTH];

    logic                               ovf_reg, ovf_next;
    logic                               done_reg, done_next;
    logic signed [smf_pkg::VALUE_W-1:0] res_val_reg, res_val_next;
    logic [smf_pkg::MODE_COUNT_W-1:0]   res_cnt_reg, res_cnt_next;
    logic                               res_ovf_reg, res_ovf_next;
    logic [WIDE_W-1:0]                  cnt_wide;
    smf_pkg::token_t                    tail;

    // Every cycle takes a new request.
    assign busy = 1'b0;

    // Head of the chain: the accepted request becomes a fresh token.
    always_comb
    begin
        tok[0].valid = start && !busy;
        tok[0].last  = last_item;
        tok[0].hit   = 1'b0;
        tok[0].have  = 1'b0;
        value[0]     = sample_value;
        best_val[0]  = '0;
        best_cnt[0]  = '0;
    end

    // Chain of cells, one table entry each.
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        smf_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .tok_in       (tok[i]),
            .value_in     (value[i]),
            .best_val_in  (best_val[i]),
            .best_cnt_in  (best_cnt[i]),
            .tok_out      (tok[i+1]),
            .value_out    (value[i+1]),
            .best_val_out (best_val[i+1]),
            .best_cnt_out (best_cnt[i+1])
        );
    end

    assign tail = tok[TABLE_DEPTH];

    // Tail: gather dropped samples and register the result of a closed set.
    always_comb
    begin
        cnt_wide     = WIDE_W'(best_cnt[TABLE_DEPTH]);
        ovf_next     = ovf_reg || (tail.valid && !tail.hit);
        done_next    = tail.valid && tail.last;
        res_val_next = best_val[TABLE_DEPTH];
        res_ovf_next = ovf_next;
        if (cnt_wide > OUT_MAX)
        begin
            res_cnt_next = smf_pkg::MODE_COUNT_W'(OUT_MAX);
        end
        else
        begin
            res_cnt_next = smf_pkg::MODE_COUNT_W'(cnt_wide);
        end
        if (done_next)
        begin
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            ovf_reg  <= ovf_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            res_val_reg <= res_val_next;
            res_cnt_reg <= res_cnt_next;
            res_ovf_reg <= res_ovf_next;
        end
    end

    assign mode_valid     = done_reg;
    assign mode_value     = res_val_reg;
    assign mode_count     = res_cnt_reg;
    assign table_overflow = res_ovf_reg;

    // A result only comes for an accepted closing request that has passed the cells and the result register.
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        mode_valid |-> $past(start && last_item && !busy, TABLE_DEPTH + 1))
        else $error("result without a closing request at the chain latency");

    // The closing sample always finds at least one entry in the table.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        mode_valid |-> (mode_count != '0))
        else $error("result with a zero count");

    // The overflow flag is cleared when its set closes.
    a_ovf_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        mode_valid |-> !ovf_reg)
        else $error("overflow flag carried into the next set");

endmodule

`default_nettype wire

// File: tb/sv/statistical_mode_finder_test.sv
`timescale 1ns / 100ps

module statistical_mode_finder_test;

    localparam int TABLE_DEPTH    = smf_pkg::TABLE_DEPTH_DEF;
    localparam int COUNT_WIDTH    = smf_pkg::COUNT_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 4 * TABLE_DEPTH + 2000;
    localparam int PHASE_ITEMS    = 573;

    typedef logic signed [smf_pkg::VALUE_W-1:0] sample_t;

    // One predicted mode result.
    typedef struct {
        sample_t                          value;
        logic [smf_pkg::MODE_COUNT_W-1:0] count;
        logic                             overflow;
    } mode_result_t;

    // Predicts the mode of each set and checks the results in order.
    class mode_scoreboard;
        sample_t         table_value [TABLE_DEPTH];
        longint unsigned table_count [TABLE_DEPTH];
        int              entries_used;
        bit              dropped_value;
        mode_result_t    expected_modes [$];
        int              mismatches;
        int              samples_seen;
        int              modes_checked;
        int              overflow_sets;
        int              saturated_sets;

        function new();
            entries_used   = 0;
            dropped_value  = 0;
            mismatches     = 0;
            samples_seen   = 0;
            modes_checked  = 0;
            overflow_sets  = 0;
            saturated_sets = 0;
        endfunction

        // Counts one accepted sample and predicts the mode when it closes its set.
        function void note_request(sample_t value, logic last);
            longint unsigned count_max;
            longint unsigned best_count;
            sample_t         best_value;
            bit              found;
            mode_result_t    mode;
            count_max = (64'd1 << COUNT_WIDTH) - 1;
            samples_seen++;
            found = 0;
            for (int i = 0; i < entries_used; i++)
            begin
                if (!found && table_value[i] == value)
                begin
                    found = 1;
                    if (table_count[i] < count_max)
                        table_count[i]++;
                end
            end
            if (!found)
            begin
                if (entries_used < TABLE_DEPTH)
                begin
                    table_value[entries_used] = value;
                    table_count[entries_used] = 1;
                    entries_used++;
                end
                else
                begin
                    dropped_value = 1;
                end
            end
            if (!last)
                return;

            // Highest count wins; on a tie the smaller signed value wins.
            best_count = 0;
            best_value = '0;
            for (int i = 0; i < entries_used; i++)
            begin
                if (i == 0 || table_count[i] > best_count ||
                    (table_count[i] == best_count && table_value[i] < best_value))
                begin
                    best_count = table_count[i];
                    best_value = table_value[i];
                end
            end
            mode.value    = best_value;
            mode.count    = (best_count > 64'hFFFF) ? 16'hFFFF :
                            best_count[smf_pkg::MODE_COUNT_W-1:0];
            mode.overflow = dropped_value;
            if (dropped_value)
                overflow_sets++;
            if (best_count >= count_max)
                saturated_sets++;
            expected_modes.push_back(mode);
            entries_used  = 0;
            dropped_value = 0;
        endfunction

        function void flag_mismatch(string what);
            if (mismatches < 10)
                $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endfunction

        // Compares one result with the oldest prediction.
        function void check_result(sample_t value, logic [smf_pkg::MODE_COUNT_W-1:0] count,
                                   logic ovf);
            mode_result_t want;
            if (expected_modes.size() == 0)
            begin
                flag_mismatch($sformatf(
                    "result value=%0d count=%0d overflow=%0b with no set pending",
                    value, count, ovf));
                return;
            end
            want = expected_modes.pop_front();
            modes_checked++;
            if (value !== want.value || count !== want.count || ovf !== want.overflow)
                flag_mismatch($sformatf(
                    "expected value=%0d count=%0d overflow=%0b, got value=%0d count=%0d overflow=%0b",
                    want.value, want.count, want.overflow, value, count, ovf));
        endfunction

        function int pending();
            return expected_modes.size();
        endfunction

        // Any prediction still waiting at the end is a failure.
        function void close_out();
            while (expected_modes.size() != 0)
            begin
                void'(expected_modes.pop_front());
                flag_mismatch("predicted result never arrived");
            end
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    sample_t sample_value = '0;
    logic    last_item = 1'b0;
    logic    mode_valid;
    sample_t mode_value;
    logic [smf_pkg::MODE_COUNT_W-1:0] mode_count;
    logic    table_overflow;

    mode_scoreboard tracker;
    int items_sent = 0;
    int quiet_cycles = 0;

    statistical_mode_finder #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .sample_value   (sample_value),
        .last_item      (last_item),
        .mode_valid     (mode_valid),
        .mode_value     (mode_value),
        .mode_count     (mode_count),
        .table_overflow (table_overflow)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Observe requests and results at the rising edge, and stop a hung run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                tracker.note_request(sample_value, last_item);
            if (mode_valid)
                tracker.check_result(mode_value, mode_count, table_overflow);
            if ((start && !busy) || mode_valid)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: nothing accepted for %0d cycles", quiet_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Presents one request and holds it until the block takes it.
    task automatic send_sample(input sample_t value, input logic last);
        @(negedge clk);
        start        <= 1'b1;
        sample_value <= value;
        last_item    <= last;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    // Keeps start low for some cycles while the data lines carry noise.
    task automatic pause_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start        <= 1'b0;
            sample_value <= $urandom;
            last_item    <= $urandom_range(1);
        end
    endtask

    // Idles each cycle with the given chance in a hundred before the next request.
    task automatic random_gap(input int idle_pct);
        int cycles;
        cycles = 0;
        while ($urandom_range(99) < idle_pct)
            cycles++;
        pause_sender(cycles);
    endtask

    // Waits until every predicted result has come, then out through the chain latency.
    task automatic drain_results();
        pause_sender(1);
        while (tracker.pending() != 0)
            @(posedge clk);
        pause_sender(TABLE_DEPTH + 8);
    endtask

    task automatic send_set(input sample_t values [$], input int idle_pct);
        foreach (values[i])
        begin
            random_gap(idle_pct);
            send_sample(values[i], i == values.size() - 1);
        end
    endtask

    // Mix of small values, extremes and full-range values.
    function automatic sample_t pick_value();
        case ($urandom_range(3))
            0: return sample_t'(int'($urandom_range(6)) - 3);
            1:
            begin
                case ($urandom_range(4))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sh8000_0001;
                    3: return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // One random set: mostly short sets from a small pool so counts repeat and tie,
    // some longer ones, a few of scattered values, and now and then a set longer than the table.
    task automatic random_set(input int idle_pct);
        sample_t values [$];
        sample_t pool [8];
        sample_t base;
        sample_t stride;
        int      kind;
        int      len;
        int      pool_n;
        kind   = $urandom_range(99);
        pool_n = $urandom_range(1, 8);
        foreach (pool[i])
            pool[i] = pick_value();
        if (kind < 97)
        begin
            if (kind < 70)
                len = $urandom_range(1, 12);
            else if (kind < 90)
                len = $urandom_range(13, 60);
            else
                len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                values.push_back(kind >= 90 ? pick_value() : pool[$urandom_range(pool_n - 1)]);
        end
        else
        begin
            // An odd stride keeps every value of the walk distinct.
            base   = $urandom;
            stride = $urandom | 1;
            len    = $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 40);
            for (int i = 0; i < len; i++)
                values.push_back($urandom_range(9) == 0 ? base : base + i * stride);
        end
        send_set(values, idle_pct);
    endtask

    initial
    begin
        sample_t values [$];
        int      idle_pcts [3];
        int      phase_goal;
        tracker   = new();
        idle_pcts = '{0, 86, 36};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed sets: extremes, ties broken toward the smaller value, plain majority.
        values = '{32'sh8000_0000};
        send_set(values, 0);
        values = '{32'sh7FFF_FFFF};
        send_set(values, 0);
        values = '{32'sd0, -32'sd1, -32'sd1, 32'sd0};
        send_set(values, 0);
        values = '{32'sh7FFF_FFFF, 32'sh8000_0000};
        send_set(values, 0);
        values = '{32'sd5, 32'sd5, 32'sd7, 32'sd7, 32'sd7, -32'sd3};
        send_set(values, 0);
        values = '{32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
                   32'sh5555_5555};
        send_set(values, 0);

        // Full table: new values are dropped, values already held still count.
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_sample(sample_t'(i), 1'b0);
        send_sample(32'sd1000, 1'b0);
        send_sample(32'sd1000, 1'b0);
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd1000, 1'b1);
        drain_results();

        // Random sets under several sender idling rates.
        foreach (idle_pcts[p])
        begin
            phase_goal = items_sent + PHASE_ITEMS;
            while (items_sent < phase_goal)
                random_set(idle_pcts[p]);
            drain_results();
        end

        tracker.close_out();
        $display("Covered %0d samples in %0d sets under three sender idling rates;",
                 tracker.samples_seen, tracker.modes_checked);
        $display("%0d sets overflowed the table, %0d saturated a count.",
                 tracker.overflow_sets, tracker.saturated_sets);
        $display("Mismatches: %0d", tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
